/* sv/tmis_pkg.sv */
// Package with the types, codes and helpers of the timed mode indicator sequencer.
package tmis_pkg;

  // Width of the millisecond time base and of all time differences.
  localparam int TIME_BITS = 32;
  typedef logic [TIME_BITS-1:0] time_t;

  // Number of result slots one input word can fill, in delivery order.
  localparam int NUM_SLOTS = 8;
  localparam int SLOT_BITS = $clog2(NUM_SLOTS);

  // Input operations.
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_BEAT = 2'd1,
    OP_RX   = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // Bus codes.
  localparam logic [1:0] BUS_0 = 2'd0;
  localparam logic [1:0] BUS_1 = 2'd1;
  localparam logic [1:0] BUS_2 = 2'd2;

  // Side codes.
  localparam logic [1:0] SIDE_DEFEND = 2'd0;
  localparam logic [1:0] SIDE_OFFEND = 2'd1;
  localparam logic [1:0] SIDE_NONE   = 2'd2;

  // Result kinds.
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_LED   = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_BEAT_MASK   = 3'd0;
  localparam logic [2:0] REG_SELF_TEST   = 3'd1;
  localparam logic [2:0] REG_CHALLENGE   = 3'd2;
  localparam logic [2:0] REG_SW_SHOW     = 3'd3;
  localparam logic [2:0] REG_SW_RELEASE  = 3'd4;

  // Received identifiers.
  localparam logic [10:0] ID_TO_OFFEND  = 11'h020;
  localparam logic [10:0] ID_TO_DEFEND  = 11'h030;
  localparam logic [10:0] ID_SELF_TEST  = 11'h040;
  localparam logic [10:0] ID_CHALLENGE  = 11'h050;
  localparam logic [10:0] ID_HALT_CLEAR = 11'h090;
  localparam logic [10:0] ID_HALT_KEEP  = 11'h100;

  // Transmitted identifiers.
  localparam logic [10:0] ID_BEAT_BASE  = 11'h100;
  localparam logic [10:0] ID_ST_BEGIN   = 11'h105;
  localparam logic [10:0] ID_ST_END     = 11'h106;
  localparam logic [10:0] ID_CH_BEGIN   = 11'h107;
  localparam logic [10:0] ID_CH_END     = 11'h108;
  localparam logic [10:0] ID_DEFEND_ANN = 11'h109;
  localparam logic [10:0] ID_OFFEND_ANN = 11'h10A;

  // Blink phase: the first color of a pair shows above this point.
  localparam logic [8:0] BLINK_MASK_BITS = 9'h1FF;
  localparam logic [8:0] BLINK_SPLIT     = 9'd256;

  // Colors.
  localparam logic [2:0] COL_GOLD    = 3'd0;
  localparam logic [2:0] COL_PINK    = 3'd1;
  localparam logic [2:0] COL_BLUE    = 3'd2;
  localparam logic [2:0] COL_GREEN   = 3'd3;
  localparam logic [2:0] COL_CYAN    = 3'd4;
  localparam logic [2:0] COL_ORANGE  = 3'd5;
  localparam logic [2:0] COL_INDIGO  = 3'd6;
  localparam logic [2:0] COL_MAGENTA = 3'd7;

  // One result word without its last flag.
  typedef struct packed {
    logic        kind;
    logic [1:0]  tx_bus;
    logic [10:0] tx_id;
    logic [7:0]  tx_byte;
    logic [2:0]  color;
  } res_t;

  // Transmit frame command; the data byte is the identifier minus 0x100.
  function automatic res_t mk_frame(input logic [1:0] bus, input logic [10:0] id);
    res_t r;
    r.kind    = KIND_FRAME;
    r.tx_bus  = bus;
    r.tx_id   = id;
    r.tx_byte = id[7:0];
    r.color   = COL_GOLD;
    return r;
  endfunction

  // LED color command.
  function automatic res_t mk_led(input logic [2:0] col);
    res_t r;
    r.kind    = KIND_LED;
    r.tx_bus  = BUS_0;
    r.tx_id   = '0;
    r.tx_byte = '0;
    r.color   = col;
    return r;
  endfunction

endpackage

/* sv/timed_mode_indicator_sequencer_top.sv */
// Timed mode indicator sequencer: state update per input word and serial result drain.
// The first result of an input word appears in the cycle after the word is accepted.
// Throughput: one result word per cycle while out_stall is low; an input word yields at most six
// result words, drained one at a time from the slot buffer by the single result port.
// The next input word is taken in the same cycle as the final result of the previous one.
// Synchronous active-high reset clears all flags, times and pending results and loads
// the configuration registers with their default values.
module timed_mode_indicator_sequencer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [1:0]  rx_bus,
  input  logic [10:0] rx_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [1:0]  tx_bus,
  output logic [10:0] tx_id,
  output logic [7:0]  tx_byte,
  output logic [2:0]  color,
  output logic        last,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data
);
  import tmis_pkg::*;

  // Configuration registers.
  logic [3:0]  beat_mask;
  logic [15:0] self_test_ms;
  logic [15:0] challenge_ms;
  logic [15:0] switch_show_ms;
  logic [15:0] switch_release_ms;

  // Sequencer state.
  time_t      time_ms, time_ms_next;
  logic [1:0] side, side_next;
  time_t      side_time, side_time_next;
  logic       busy, busy_next;
  logic       halted, halted_next;
  logic       st_req, st_req_next;
  logic       st_ann, st_ann_next;
  logic       st_run, st_run_next;
  time_t      st_start, st_start_next;
  logic       ch_req, ch_req_next;
  logic       ch_ann, ch_ann_next;
  logic       ch_run, ch_run_next;
  time_t      ch_start, ch_start_next;
  logic       def_ann, def_ann_next;
  logic       off_ann, off_ann_next;
  logic [2:0] beat_slot, beat_slot_next;

  // Result slot buffer.
  res_t                 slot [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] pend;
  res_t                 cand [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] cand_v;

  // Handshake terms.
  logic                 in_acc;
  logic                 out_acc;
  logic [SLOT_BITS-1:0] sel;
  logic [NUM_SLOTS-1:0] sel_hot;

  // Pass temporaries.
  time_t      time_inc;
  time_t      st_dt;
  time_t      ch_dt;
  time_t      sw_dt;
  logic       blink_first;
  logic [2:0] beat_s;

  // Pick the lowest pending slot; it is the final word when nothing else is left.
  always_comb begin
    sel = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (pend[i]) sel = SLOT_BITS'(i);
    end
  end

  assign sel_hot   = NUM_SLOTS'(1) << sel;
  assign out_valid = |pend;
  assign kind      = slot[sel].kind;
  assign tx_bus    = slot[sel].tx_bus;
  assign tx_id     = slot[sel].tx_id;
  assign tx_byte   = slot[sel].tx_byte;
  assign color     = slot[sel].color;
  assign last      = ~|(pend & ~sel_hot);
  assign out_acc   = out_valid && !out_stall;
  assign in_stall  = out_valid && !(out_acc && last);
  assign in_acc    = in_valid && !in_stall;

  // Next state and result slots for the word at the input.
  always_comb begin
    time_ms_next   = time_ms;
    side_next      = side;
    side_time_next = side_time;
    busy_next      = busy;
    halted_next    = halted;
    st_req_next    = st_req;
    st_ann_next    = st_ann;
    st_run_next    = st_run;
    st_start_next  = st_start;
    ch_req_next    = ch_req;
    ch_ann_next    = ch_ann;
    ch_run_next    = ch_run;
    ch_start_next  = ch_start;
    def_ann_next   = def_ann;
    off_ann_next   = off_ann;
    beat_slot_next = beat_slot;
    cand_v         = '0;
    for (int i = 0; i < NUM_SLOTS; i++) cand[i] = mk_led(COL_GOLD);

    time_inc    = time_ms + TIME_BITS'(1);
    st_dt       = time_inc - (st_req ? time_inc : st_start);
    ch_dt       = time_inc - (ch_req ? time_inc : ch_start);
    sw_dt       = time_inc - side_time;
    blink_first = (time_inc[8:0] & BLINK_MASK_BITS) > BLINK_SPLIT;
    beat_s      = beat_slot + 3'd1;

    unique case (op_t'(op))
      OP_TICK: begin
        time_ms_next = time_inc;
        if (!halted) begin
          // Self test: start, announce, blink until its time is up, then end.
          if (st_req) begin
            st_start_next = time_inc;
            st_req_next   = 1'b0;
          end
          if (st_req || st_ann) begin
            cand_v[0]   = 1'b1;
            cand[0]     = mk_frame(BUS_2, ID_ST_BEGIN);
            st_ann_next = 1'b0;
          end
          if (st_req || st_run) begin
            cand_v[1]   = 1'b1;
            st_run_next = 1'b1;
            if (st_dt <= TIME_BITS'(self_test_ms)) begin
              cand[1] = mk_led(blink_first ? COL_GOLD : COL_PINK);
            end else begin
              cand[1]     = mk_frame(BUS_2, ID_ST_END);
              st_run_next = 1'b0;
              busy_next   = 1'b0;
            end
          end

          // Challenge: same sequence with its own identifiers and length.
          if (ch_req) begin
            ch_start_next = time_inc;
            ch_req_next   = 1'b0;
          end
          if (ch_req || ch_ann) begin
            cand_v[2]   = 1'b1;
            cand[2]     = mk_frame(BUS_2, ID_CH_BEGIN);
            ch_ann_next = 1'b0;
          end
          if (ch_req || ch_run) begin
            cand_v[3]   = 1'b1;
            ch_run_next = 1'b1;
            if (ch_dt <= TIME_BITS'(challenge_ms)) begin
              cand[3] = mk_led(blink_first ? COL_BLUE : COL_GREEN);
            end else begin
              cand[3]     = mk_frame(BUS_2, ID_CH_END);
              ch_run_next = 1'b0;
              busy_next   = 1'b0;
            end
          end

          // Side switch windows.
          if (side == SIDE_DEFEND && sw_dt < TIME_BITS'(switch_show_ms)) begin
            cand_v[4] = 1'b1;
            cand[4]   = mk_led(blink_first ? COL_CYAN : COL_ORANGE);
            if (def_ann) begin
              cand_v[5]    = 1'b1;
              cand[5]      = mk_frame(BUS_2, ID_DEFEND_ANN);
              def_ann_next = 1'b0;
            end
            if (sw_dt > TIME_BITS'(switch_release_ms)) busy_next = 1'b0;
          end
          if (side == SIDE_OFFEND && sw_dt < TIME_BITS'(switch_show_ms)) begin
            cand_v[6] = 1'b1;
            cand[6]   = mk_led(blink_first ? COL_INDIGO : COL_MAGENTA);
            if (off_ann) begin
              cand_v[7]    = 1'b1;
              cand[7]      = mk_frame(BUS_2, ID_OFFEND_ANN);
              off_ann_next = 1'b0;
            end
            if (sw_dt > TIME_BITS'(switch_release_ms)) busy_next = 1'b0;
          end
        end
      end

      OP_BEAT: begin
        // Rotate through the four keep-alive slots.
        beat_slot_next = beat_s;
        if (beat_s >= 3'd1 && beat_s <= 3'd4 && beat_mask[2'(beat_s - 3'd1)]) begin
          cand_v[0] = 1'b1;
          cand[0]   = mk_frame((beat_s <= 3'd2) ? BUS_0 : BUS_1,
                               ID_BEAT_BASE + {8'd0, beat_s});
        end
        if (beat_s >= 3'd4) beat_slot_next = 3'd0;
      end

      OP_RX: begin
        // Received frame decode.
        if (rx_bus == BUS_0) begin
          if (rx_id == ID_TO_OFFEND) begin
            if (!busy) begin
              side_next      = SIDE_OFFEND;
              busy_next      = 1'b1;
              off_ann_next   = 1'b1;
              side_time_next = time_ms;
            end
          end else if (rx_id == ID_HALT_CLEAR) begin
            halted_next  = 1'b1;
            st_req_next  = 1'b0;
            st_ann_next  = 1'b0;
            st_run_next  = 1'b0;
            ch_req_next  = 1'b0;
            ch_ann_next  = 1'b0;
            ch_run_next  = 1'b0;
            def_ann_next = 1'b0;
            off_ann_next = 1'b0;
            busy_next    = 1'b0;
          end
        end else if (rx_bus == BUS_2) begin
          if (rx_id == ID_TO_DEFEND) begin
            if (!busy) begin
              side_next      = SIDE_DEFEND;
              busy_next      = 1'b1;
              def_ann_next   = 1'b1;
              side_time_next = time_ms;
            end
          end else if (rx_id == ID_HALT_KEEP) begin
            halted_next = 1'b1;
          end
        end else if (rx_bus == BUS_1) begin
          if (rx_id == ID_SELF_TEST) begin
            if (!busy) begin
              st_req_next = 1'b1;
              busy_next   = 1'b1;
            end
          end else if (rx_id == ID_CHALLENGE) begin
            if (!busy) begin
              ch_req_next = 1'b1;
              busy_next   = 1'b1;
            end
          end
        end
      end

      default: begin
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_mask         <= 4'd15;
      self_test_ms      <= 16'd8000;
      challenge_ms      <= 16'd25000;
      switch_show_ms    <= 16'd2100;
      switch_release_ms <= 16'd2000;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_BEAT_MASK:  beat_mask         <= wr_data[3:0];
        REG_SELF_TEST:  self_test_ms      <= wr_data;
        REG_CHALLENGE:  challenge_ms      <= wr_data;
        REG_SW_SHOW:    switch_show_ms    <= wr_data;
        REG_SW_RELEASE: switch_release_ms <= wr_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer state update on an accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      time_ms   <= '0;
      side      <= SIDE_NONE;
      side_time <= '0;
      busy      <= 1'b0;
      halted    <= 1'b0;
      st_req    <= 1'b0;
      st_ann    <= 1'b0;
      st_run    <= 1'b0;
      st_start  <= '0;
      ch_req    <= 1'b0;
      ch_ann    <= 1'b0;
      ch_run    <= 1'b0;
      ch_start  <= '0;
      def_ann   <= 1'b0;
      off_ann   <= 1'b0;
      beat_slot <= '0;
    end else if (in_acc) begin
      time_ms   <= time_ms_next;
      side      <= side_next;
      side_time <= side_time_next;
      busy      <= busy_next;
      halted    <= halted_next;
      st_req    <= st_req_next;
      st_ann    <= st_ann_next;
      st_run    <= st_run_next;
      st_start  <= st_start_next;
      ch_req    <= ch_req_next;
      ch_ann    <= ch_ann_next;
      ch_run    <= ch_run_next;
      ch_start  <= ch_start_next;
      def_ann   <= def_ann_next;
      off_ann   <= off_ann_next;
      beat_slot <= beat_slot_next;
    end
  end

  // Pending mask: load on accept, clear each slot as its word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (in_acc) begin
      pend <= cand_v;
    end else if (out_acc) begin
      pend <= pend & ~sel_hot;
    end
  end

  // Result payloads.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < NUM_SLOTS; i++) slot[i] <= cand[i];
    end
  end

endmodule
